// ----- hw/rtl/odo_pkg.sv -----
// ----------------------------------------------------------------------------
// odo_pkg
// Shared widths, register map, reset values, fixed-point constants for the
// sine table and the controller command bundle.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int POS_WIDTH_DEF       = 48;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int STEP_W  = 2;
  localparam int DIST_W  = 24;
  localparam int ANGLE_W = 32;
  localparam int HEAD_W  = 32;
  localparam int FWD_W   = 32;
  localparam int TRIG_W  = 31;
  localparam int FRAC_W  = 30;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index is paddr[2]
  localparam logic REG_DIST  = 1'b0;
  localparam logic REG_ANGLE = 1'b1;

  localparam logic [DIST_W-1:0]  DIST_RESET  = 24'd3016;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 32'd629114;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << FRAC_W;

  typedef struct packed {
    logic capture;
    logic rom_load;
    logic rom_sel_sin;
    logic mul_en;
    logic add_x;
    logic add_y;
    logic finish;
  } ctrl_cmd_t;

endpackage

// ----- hw/rtl/odo_if.sv -----
// ----------------------------------------------------------------------------
// odo_if
// Valid/ready channels: step input channel and odometry result channel.
// ----------------------------------------------------------------------------
interface odo_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [odo_pkg::STEP_W-1:0] left_step;
  logic signed [odo_pkg::STEP_W-1:0] right_step;

  modport source (output valid, output left_step, output right_step, input ready);
  modport sink   (input valid, input left_step, input right_step, output ready);
endinterface

interface odo_out_if #(
  parameter int POS_WIDTH = odo_pkg::POS_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [POS_WIDTH-1:0]       x_position;
  logic signed [POS_WIDTH-1:0]       y_position;
  logic [odo_pkg::HEAD_W-1:0]        heading_angle;
  logic signed [odo_pkg::FWD_W-1:0]  forward_total;

  modport source (output valid, output x_position, output y_position,
                  output heading_angle, output forward_total, input ready);
  modport sink   (input valid, input x_position, input y_position,
                  input heading_angle, input forward_total, output ready);
endinterface

// ----- hw/rtl/odo_regs.sv -----
// ----------------------------------------------------------------------------
// odo_regs
// APB configuration registers: distance per step and angle per turn step.
// ----------------------------------------------------------------------------
module odo_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [odo_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [odo_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [odo_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [odo_pkg::DIST_W-1:0]        dist_per_step_o,
  output logic [odo_pkg::ANGLE_W-1:0]       angle_per_turn_step_o
);

  logic [odo_pkg::DIST_W-1:0]  dist_q, dist_d;
  logic [odo_pkg::ANGLE_W-1:0] angle_q, angle_d;
  logic                        wr_en;
  logic                        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    dist_d  = dist_q;
    angle_d = angle_q;
    if (wr_en) begin
      case (reg_idx)
        odo_pkg::REG_DIST:  dist_d  = pwdata[odo_pkg::DIST_W-1:0];
        odo_pkg::REG_ANGLE: angle_d = pwdata[odo_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      odo_pkg::REG_DIST:  prdata = odo_pkg::APB_DATA_W'(dist_q);
      odo_pkg::REG_ANGLE: prdata = angle_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= odo_pkg::DIST_RESET;
      angle_q <= odo_pkg::ANGLE_RESET;
    end else begin
      dist_q  <= dist_d;
      angle_q <= angle_d;
    end
  end

  assign dist_per_step_o       = dist_q;
  assign angle_per_turn_step_o = angle_q;

endmodule

// ----- hw/rtl/odo_ctrl.sv -----
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer: input handshake, table reads, shared multiply and accumulate
// steps, and the output register handshake.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               fwd_nonzero_i,
  output odo_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDCOS = 3'd1;
  localparam logic [2:0] S_MULX  = 3'd2;
  localparam logic [2:0] S_ADDX  = 3'd3;
  localparam logic [2:0] S_ADDY  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RDCOS;
        end
      end
      S_RDCOS: begin
        cmd_o.rom_load = 1'b1;
        state_d        = fwd_nonzero_i ? S_MULX : S_DONE;
      end
      S_MULX: begin
        // cosine product while the sine is read
        cmd_o.mul_en      = 1'b1;
        cmd_o.rom_load    = 1'b1;
        cmd_o.rom_sel_sin = 1'b1;
        state_d           = S_ADDX;
      end
      S_ADDX: begin
        cmd_o.add_x  = 1'b1;
        cmd_o.mul_en = 1'b1;
        state_d      = S_ADDY;
      end
      S_ADDY: begin
        cmd_o.add_y = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/odo_dp.sv -----
// ----------------------------------------------------------------------------
// odo_dp
// Datapath: step decode, sine/cosine table, shared multiplier, rounding,
// saturating position accumulators, heading and forward counters, result
// register.
// ----------------------------------------------------------------------------
module odo_dp #(
  parameter int POS_WIDTH       = odo_pkg::POS_WIDTH_DEF,
  parameter int SINE_TABLE_BITS = odo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  odo_pkg::ctrl_cmd_t                cmd_i,
  input  logic signed [odo_pkg::STEP_W-1:0] left_step_i,
  input  logic signed [odo_pkg::STEP_W-1:0] right_step_i,
  input  logic [odo_pkg::DIST_W-1:0]        dist_per_step_i,
  input  logic [odo_pkg::ANGLE_W-1:0]       angle_per_turn_step_i,
  output logic                              fwd_nonzero_o,
  output logic signed [POS_WIDTH-1:0]       x_position_o,
  output logic signed [POS_WIDTH-1:0]       y_position_o,
  output logic [odo_pkg::HEAD_W-1:0]        heading_angle_o,
  output logic signed [odo_pkg::FWD_W-1:0]  forward_total_o
);

  localparam int TB       = SINE_TABLE_BITS;
  localparam int AW       = TB - 1;
  localparam int QtrCnt   = 1 << (TB - 2);
  localparam int DistMagW = odo_pkg::DIST_W + 2;
  localparam int ProdW    = DistMagW + odo_pkg::TRIG_W;
  localparam int MagW     = ProdW - odo_pkg::FRAC_W;
  localparam int DeltaW   = MagW + 1;
  localparam int TurnPW   = odo_pkg::ANGLE_W + 4;

  // quarter-wave table, built at elaboration from a nested taylor series in q30
  logic [odo_pkg::TRIG_W-1:0] rom_w [QtrCnt+1];
  for (genvar g = 0; g <= QtrCnt; g++) begin : g_rom
    localparam logic [63:0] Phase   = (64'(g) * odo_pkg::HALF_PI_Q30) >> (TB - 2);
    localparam logic [63:0] PhaseSq = (Phase * Phase) >> odo_pkg::FRAC_W;
    localparam logic [63:0] Term5   =
      odo_pkg::Q30_ONE - (((PhaseSq * odo_pkg::Q30_ONE) >> odo_pkg::FRAC_W) / 64'd110);
    localparam logic [63:0] Term4   =
      odo_pkg::Q30_ONE - (((PhaseSq * Term5) >> odo_pkg::FRAC_W) / 64'd72);
    localparam logic [63:0] Term3   =
      odo_pkg::Q30_ONE - (((PhaseSq * Term4) >> odo_pkg::FRAC_W) / 64'd42);
    localparam logic [63:0] Term2   =
      odo_pkg::Q30_ONE - (((PhaseSq * Term3) >> odo_pkg::FRAC_W) / 64'd20);
    localparam logic [63:0] Term1   =
      odo_pkg::Q30_ONE - (((PhaseSq * Term2) >> odo_pkg::FRAC_W) / 64'd6);
    localparam logic [63:0] SineRaw  = (Phase * Term1) >> odo_pkg::FRAC_W;
    localparam logic [63:0] SineClip =
      (SineRaw > odo_pkg::Q30_ONE) ? odo_pkg::Q30_ONE : SineRaw;
    assign rom_w[g] = SineClip[odo_pkg::TRIG_W-1:0];
  end

  logic signed [2:0]               fwd_w, turn_w;
  logic [1:0]                      fwd_mag_w;
  logic signed [2:0]               fwd_q, turn_q;
  logic                            fwd_neg_q;
  logic [DistMagW-1:0]             dist_mag_q;
  logic [TB-1:0]                   idx_q;

  logic [TB-1:0]                   sel_idx;
  logic [1:0]                      quad;
  logic [TB-3:0]                   rem;
  logic [AW-1:0]                   rom_addr;
  logic [odo_pkg::TRIG_W-1:0]      rom_q;
  logic                            rom_neg_q;

  logic [ProdW-1:0]                prod_q;
  logic                            prod_neg_q;
  logic [ProdW-1:0]                rnd_sum;
  logic [MagW-1:0]                 mag;
  logic signed [DeltaW-1:0]        delta;

  logic signed [POS_WIDTH-1:0]     x_q, x_d, y_q, y_d, acc_sel, acc_sat;
  logic signed [POS_WIDTH:0]       acc_sum;
  logic [odo_pkg::HEAD_W-1:0]      head_q, head_d;
  logic signed [odo_pkg::FWD_W-1:0] fwdacc_q, fwdacc_d;
  logic signed [TurnPW-1:0]        turn_prod;

  // step decode: forward is right minus left, turn is right plus left
  assign fwd_w     = 3'(right_step_i) - 3'(left_step_i);
  assign turn_w    = 3'(right_step_i) + 3'(left_step_i);
  assign fwd_mag_w = fwd_w[2] ? 2'(-fwd_w) : fwd_w[1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fwd_q      <= fwd_w;
      turn_q     <= turn_w;
      fwd_neg_q  <= fwd_w[2];
      dist_mag_q <= DistMagW'(fwd_mag_w) * DistMagW'(dist_per_step_i);
      idx_q      <= head_q[odo_pkg::HEAD_W-1 -: TB];
    end
  end

  assign fwd_nonzero_o = (fwd_q != 3'sd0);

  // quadrant fold; cosine is the sine a quarter turn on
  assign sel_idx  = cmd_i.rom_sel_sin ? idx_q : idx_q + TB'(QtrCnt);
  assign quad     = sel_idx[TB-1:TB-2];
  assign rem      = sel_idx[TB-3:0];
  assign rom_addr = quad[0] ? AW'(QtrCnt) - AW'(rem) : AW'(rem);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rom_load) begin
      rom_q     <= rom_w[rom_addr];
      rom_neg_q <= quad[1];
    end
    if (cmd_i.mul_en) begin
      prod_q     <= ProdW'(dist_mag_q) * ProdW'(rom_q);
      prod_neg_q <= fwd_neg_q ^ rom_neg_q;
    end
  end

  // round half away from zero on the magnitude, then apply the sign
  assign rnd_sum = prod_q + (ProdW'(1) << (odo_pkg::FRAC_W - 1));
  assign mag     = rnd_sum[ProdW-1:odo_pkg::FRAC_W];
  assign delta   = prod_neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // shared saturating adder for x and y
  assign acc_sel = cmd_i.add_x ? x_q : y_q;
  assign acc_sum = (POS_WIDTH+1)'(acc_sel) + (POS_WIDTH+1)'(delta);

  always_comb begin
    if (acc_sum[POS_WIDTH] != acc_sum[POS_WIDTH-1]) begin
      acc_sat = acc_sum[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                                   : {1'b0, {(POS_WIDTH-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[POS_WIDTH-1:0];
    end
  end

  assign turn_prod = $signed(turn_q) * $signed({1'b0, angle_per_turn_step_i});

  always_comb begin
    x_d      = cmd_i.add_x ? acc_sat : x_q;
    y_d      = cmd_i.add_y ? acc_sat : y_q;
    head_d   = head_q;
    fwdacc_d = fwdacc_q;
    if (cmd_i.finish) begin
      head_d   = head_q - turn_prod[odo_pkg::HEAD_W-1:0];
      fwdacc_d = fwdacc_q + odo_pkg::FWD_W'(fwd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      head_q   <= '0;
      fwdacc_q <= '0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      head_q   <= head_d;
      fwdacc_q <= fwdacc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      x_position_o    <= x_q;
      y_position_o    <= y_q;
      heading_angle_o <= head_d;
      forward_total_o <= fwdacc_d;
    end
  end

endmodule

// ----- hw/rtl/differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning odometry for a two-wheel stepper base: saturating x/y
// position, binary-angle heading and a running forward step count.
// ----------------------------------------------------------------------------
// sequence: capture the tick, read the cosine, multiply it while reading the
//   sine, add to x while multiplying the sine, add to y, load the result once
//   the output slot is free; a tick without forward motion skips the multiply
//   and adds; one tick at a time, the next taken once the result is loaded
// reset: positions, heading and forward count clear; registers take defaults
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int POS_WIDTH       = odo_pkg::POS_WIDTH_DEF,
  parameter int SINE_TABLE_BITS = odo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  odo_in_if.sink                         in_i,
  odo_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [odo_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [odo_pkg::APB_DATA_W-1:0] pwdata,
  output logic [odo_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  odo_pkg::ctrl_cmd_t           cmd;
  logic                         fwd_nonzero;
  logic [odo_pkg::DIST_W-1:0]   dist_per_step;
  logic [odo_pkg::ANGLE_W-1:0]  angle_per_turn_step;

  odo_regs u_regs (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .dist_per_step_o       (dist_per_step),
    .angle_per_turn_step_o (angle_per_turn_step)
  );

  odo_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .fwd_nonzero_i (fwd_nonzero),
    .cmd_o         (cmd)
  );

  odo_dp #(
    .POS_WIDTH       (POS_WIDTH),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .left_step_i           (in_i.left_step),
    .right_step_i          (in_i.right_step),
    .dist_per_step_i       (dist_per_step),
    .angle_per_turn_step_i (angle_per_turn_step),
    .fwd_nonzero_o         (fwd_nonzero),
    .x_position_o          (out_o.x_position),
    .y_position_o          (out_o.y_position),
    .heading_angle_o       (out_o.heading_angle),
    .forward_total_o       (out_o.forward_total)
  );

endmodule

// ----- hw/rtl/odo_checker.sv -----
// ----------------------------------------------------------------------------
// odo_checker
// Port-level checks on the odometry block, attached by bind.
// ----------------------------------------------------------------------------
module odo_checker #(
  parameter int POS_WIDTH = odo_pkg::POS_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [POS_WIDTH-1:0]           x_position,
  input logic [odo_pkg::FWD_W-1:0]      forward_total,
  input logic                           pready
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  // a result never shows up right after an accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_fire) && !$past(in_fire, 2))
    else $error("result appeared too soon after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(x_position)
                                && $stable(forward_total))
    else $error("stalled result dropped or changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port stalled");

endmodule

bind differential_drive_odometry odo_checker #(
  .POS_WIDTH (POS_WIDTH)
) u_odo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .x_position    (out_o.x_position),
  .forward_total (out_o.forward_total),
  .pready        (pready)
);

// ----- dv/tb_differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Self-checking bench for the odometry block: drives step ticks over a
// valid/ready channel in random bursts, predicts position, heading and forward
// count per tick, and checks every result transaction against the prediction
// while the sink stalls and the registers move through several settings.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [odo_pkg::POS_WIDTH_DEF-1:0] x_position;
  logic signed [odo_pkg::POS_WIDTH_DEF-1:0] y_position;
  logic [odo_pkg::HEAD_W-1:0]               heading_angle;
  logic signed [odo_pkg::FWD_W-1:0]         forward_total;
} pose_t;

class pose_tracker;
  localparam int PW   = odo_pkg::POS_WIDTH_DEF;
  localparam int TBITS = odo_pkg::SINE_TABLE_BITS_DEF;
  localparam int QTR  = 1 << (TBITS - 2);
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  bit [odo_pkg::DIST_W-1:0]  distance;
  bit [odo_pkg::ANGLE_W-1:0] angle;
  longint                    x_acc;
  longint                    y_acc;
  bit [31:0]                 heading;
  bit [31:0]                 fwd_count;
  longint unsigned           quarter_wave[QTR + 1];
  pose_t                     expected_poses[$];
  int                        mismatch_count;

  function new();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned divisors[5];
    divisors = '{110, 72, 42, 20, 6};
    // taylor series of sine in q30, nested from the highest term down
    for (int p = 0; p <= QTR; p++) begin
      x  = (longint'(p) * 64'd1686629713) >> (TBITS - 2);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      foreach (divisors[i]) t = ONE_Q30 - ((x2 * t) >> 30) / divisors[i];
      s = (x * t) >> 30;
      quarter_wave[p] = (s > ONE_Q30) ? ONE_Q30 : s;
    end
    distance       = odo_pkg::DIST_RESET;
    angle          = odo_pkg::ANGLE_RESET;
    x_acc          = 0;
    y_acc          = 0;
    heading        = '0;
    fwd_count      = '0;
    mismatch_count = 0;
  endfunction

  function void set_register(logic idx, logic [31:0] data);
    if (idx == odo_pkg::REG_DIST) distance = data[odo_pkg::DIST_W-1:0];
    else angle = data;
  endfunction

  function longint trig_at(int unsigned idx);
    int unsigned quad;
    int unsigned r;
    longint      s;
    quad = (idx >> (TBITS - 2)) & 3;
    r    = idx & (QTR - 1);
    s    = (quad & 1) ? longint'(quarter_wave[QTR - r]) : longint'(quarter_wave[r]);
    return (quad & 2) ? -s : s;
  endfunction

  // product scaled by 2^-30, rounded half away from zero
  function longint round_scale(longint dist_val, longint trig);
    bit              neg;
    longint unsigned a;
    longint unsigned b;
    longint unsigned m;
    neg = (dist_val < 0) != (trig < 0);
    a   = (dist_val < 0) ? -dist_val : dist_val;
    b   = (trig < 0) ? -trig : trig;
    m   = (a * b + (ONE_Q30 >> 1)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function longint clamp_add(longint acc, longint d);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (PW - 1)) - 1;
    lo = -hi - 1;
    if (d > 0 && acc > hi - d) return hi;
    if (d < 0 && acc < lo - d) return lo;
    return acc + d;
  endfunction

  function void note_tick(logic signed [1:0] left, logic signed [1:0] right);
    longint      l;
    longint      r;
    longint      fwd;
    longint      turn;
    longint      dist_val;
    int unsigned idx;
    pose_t       p;
    l    = left;
    r    = right;
    fwd  = r - l;
    turn = r + l;
    if (fwd != 0) begin
      // trig uses the heading held before this tick
      idx  = heading >> (32 - TBITS);
      dist_val = fwd * longint'(distance);
      x_acc = clamp_add(x_acc,
                        round_scale(dist_val, trig_at((idx + QTR) & ((1 << TBITS) - 1))));
      y_acc = clamp_add(y_acc, round_scale(dist_val, trig_at(idx)));
    end
    fwd_count = fwd_count + 32'(fwd);
    heading   = heading - 32'(turn) * angle;
    p.x_position    = x_acc[PW-1:0];
    p.y_position    = y_acc[PW-1:0];
    p.heading_angle = heading;
    p.forward_total = fwd_count;
    expected_poses.push_back(p);
  endfunction

  function void check_result(pose_t got);
    pose_t want;
    if (expected_poses.size() == 0) begin
      $error("result transaction arrived with no tick pending");
      mismatch_count++;
      return;
    end
    want = expected_poses.pop_front();
    if (got.x_position !== want.x_position) begin
      $error("x_position: expected %0d, got %0d", want.x_position, got.x_position);
      mismatch_count++;
    end
    if (got.y_position !== want.y_position) begin
      $error("y_position: expected %0d, got %0d", want.y_position, got.y_position);
      mismatch_count++;
    end
    if (got.heading_angle !== want.heading_angle) begin
      $error("heading_angle: expected %0d, got %0d", want.heading_angle, got.heading_angle);
      mismatch_count++;
    end
    if (got.forward_total !== want.forward_total) begin
      $error("forward_total: expected %0d, got %0d", want.forward_total, got.forward_total);
      mismatch_count++;
    end
  endfunction

  function int pending();
    return expected_poses.size();
  endfunction
endclass

module tb_differential_drive_odometry;

  localparam longint WATCHDOG = 64'd400_000 * 10;
  localparam int     TICKS_PER_PHASE = 125;

  typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SPARSE} sink_mode_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [odo_pkg::APB_ADDR_W-1:0] paddr;
  logic [odo_pkg::APB_DATA_W-1:0] pwdata;
  logic [odo_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  odo_in_if                                         in_if ();
  odo_out_if #(.POS_WIDTH(odo_pkg::POS_WIDTH_DEF))  out_if ();

  differential_drive_odometry DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pose_tracker poses;
  int          burst_left;
  sink_mode_e  sink_mode = SINK_OPEN;
  int          sink_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(WATCHDOG);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      poses.note_tick(in_if.left_step, in_if.right_step);
    end
  end

  // sink side: check accepted results, then pick the next ready level
  always @(posedge clk_i) begin : result_side
    pose_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.x_position    = out_if.x_position;
      got.y_position    = out_if.y_position;
      got.heading_angle = out_if.heading_angle;
      got.forward_total = out_if.forward_total;
      poses.check_result(got);
    end
    if (sink_hold <= 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      sink_hold = $urandom_range(16, 160);
    end
    sink_hold--;
    case (sink_mode)
      SINK_OPEN:   out_if.ready <= 1'b1;
      SINK_CHOPPY: out_if.ready <= 1'($urandom_range(0, 1));
      default:     out_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic signed [1:0] random_step();
    int pick;
    pick = $urandom_range(0, 9);
    // pattern 10 shows up about one tick in ten
    if (pick == 0) return 2'b10;
    return (pick % 3 == 0) ? 2'b11 : 2'(pick % 3 - 1);
  endfunction

  task automatic send_tick(input logic signed [1:0] left, input logic signed [1:0] right);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(1, 3) == 1) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.left_step  <= left;
    in_if.right_step <= right;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic park_input();
    in_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // drain all outstanding transactions before touching the registers
  task automatic settle();
    park_input();
    // let the monitor note the last accepted tick first
    @(posedge clk_i);
    while (poses.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    poses.set_register(idx, data);
  endtask

  initial begin
    poses = new();
    burst_left = 0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.left_step  <= '0;
    in_if.right_step <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every pair of step patterns under the reset settings
    for (int l = 0; l < 4; l++) begin
      for (int r = 0; r < 4; r++) send_tick(2'(l), 2'(r));
    end

    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        settle();
        case (phase)
          1: begin
            // upper bits of the distance word are dropped
            apb_write(odo_pkg::REG_DIST, 32'hFFFF_FFFF);
            apb_write(odo_pkg::REG_ANGLE, 32'h4000_0000);
          end
          2: begin
            apb_write(odo_pkg::REG_DIST, 32'd1);
            apb_write(odo_pkg::REG_ANGLE, 32'hFFFF_FFFF);
          end
          3: begin
            apb_write(odo_pkg::REG_DIST, 32'd0);
            apb_write(odo_pkg::REG_ANGLE, 32'd0);
          end
          default: begin
            apb_write(odo_pkg::REG_DIST, {8'($urandom), 24'($urandom_range(1, 24'hFF_FFFF))});
            apb_write(odo_pkg::REG_ANGLE, $urandom >> $urandom_range(0, 24));
          end
        endcase
      end
      if (phase == 1) begin
        // quarter-turn steps land the heading on each quadrant boundary
        repeat (5) send_tick(2'sd0, 2'sd1);
        repeat (3) send_tick(-2'sd1, 2'sd0);
        send_tick(2'b10, 2'sd1);
      end
      repeat (TICKS_PER_PHASE) send_tick(random_step(), random_step());
    end

    settle();
    repeat (12) @(posedge clk_i);
    if (poses.mismatch_count == 0 && poses.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- differential_drive_odometry.f -----
hw/rtl/odo_pkg.sv
hw/rtl/odo_if.sv
hw/rtl/odo_regs.sv
hw/rtl/odo_ctrl.sv
hw/rtl/odo_dp.sv
hw/rtl/differential_drive_odometry.sv
hw/rtl/odo_checker.sv
dv/tb_differential_drive_odometry.sv
